// ----- design/shifted_negative_emboss_core_assert.svh -----
// assertion macros shared by the checker of the emboss core
`ifndef SHIFTED_NEGATIVE_EMBOSS_CORE_ASSERT_SVH
`define SHIFTED_NEGATIVE_EMBOSS_CORE_ASSERT_SVH

// checked while out of reset
`define SNE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define SNE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- design/sne_pkg.sv -----
// types and constants of the shifted negative emboss core
package sne_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int DELAY_DEPTH = 16384;

  localparam int ADDR_W  = $clog2(DELAY_DEPTH);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int WIDTH_W = 11;
  localparam int SHIFT_W = 4;
  localparam int ROW_W   = 4;
  localparam int PIX_W   = 8;
  localparam int CFG_W   = 11;
  localparam int IDX_W   = 2;
  localparam int PROD_W  = SHIFT_W + WIDTH_W;
  localparam int CMP_W   = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;

  localparam logic [ROW_W-1:0]   ROW_LIMIT   = 4'd15;
  localparam logic [PIX_W-1:0]   NEUTRAL     = 8'd128;
  localparam logic [PIX_W-1:0]   PIX_MAX     = 8'd255;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd320;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd5;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [IDX_W-1:0] {
    CFG_IMAGE_WIDTH = 2'd0,
    CFG_SHIFT_X     = 2'd1,
    CFG_SHIFT_Y     = 2'd2
  } cfg_index_e;

  // one classified pixel on its way from the front to the back
  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic              hit;
    logic              same;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
  } sne_item_t;

endpackage

// ----- design/shifted_negative_emboss_core.sv -----
// top level of the shifted negative emboss core
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  cfg     | in        | cfg_we_i                | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i / in_stall_o | pixel_in_i, start_of_frame_i
//  out     | out       | out_valid_o/out_stall_i | pixel_out_o
//
// one pixel per clock sustained while out_stall_i stays low; a taken beat passes
// through the queue slot, the store read and the output register in turn
// the delay store is a single memory with one write and one read per beat
// reset clears counters, pointers and valids; store contents are undefined
// a stall on the output fills the two-entry queue before in_stall_o rises
module shifted_negative_emboss_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [sne_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [sne_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [sne_pkg::PIX_W-1:0] pixel_in_i,
  input  logic                      start_of_frame_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [sne_pkg::PIX_W-1:0] pixel_out_o
);

  sne_pkg::sne_item_t push_item, pop_item;
  logic               push, full, pop, queue_valid;

  sne_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pixel_in_i       (pixel_in_i),
    .start_of_frame_i (start_of_frame_i),
    .full_i           (full),
    .push_o           (push),
    .item_o           (push_item)
  );

  sne_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .item_o  (pop_item)
  );

  sne_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (queue_valid),
    .item_i       (pop_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_out_o  (pixel_out_o)
  );

endmodule

// ----- design/sne_front.sv -----
// front end: config registers, position counters and store addressing
module sne_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [sne_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [sne_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [sne_pkg::PIX_W-1:0] pixel_in_i,
  input  logic                      start_of_frame_i,
  input  logic                      full_i,
  output logic                      push_o,
  output sne_pkg::sne_item_t        item_o
);

  logic [sne_pkg::WIDTH_W-1:0] width_q;
  logic [sne_pkg::SHIFT_W-1:0] shift_x_q, shift_y_q;
  logic [sne_pkg::COL_W-1:0]   col_q, col_d, col_cur;
  logic [sne_pkg::ROW_W-1:0]   row_q, row_d, row_cur;
  logic [sne_pkg::ADDR_W-1:0]  ptr_q, ptr_d;
  logic [sne_pkg::WIDTH_W-1:0] width_eff;
  logic [sne_pkg::PROD_W-1:0]  prod;
  logic [sne_pkg::PROD_W:0]    offset_sum;
  logic [sne_pkg::ADDR_W-1:0]  offset;
  logic [sne_pkg::CMP_W-1:0]   col_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= sne_pkg::WIDTH_RESET;
      shift_x_q <= sne_pkg::SHIFT_RESET;
      shift_y_q <= sne_pkg::SHIFT_RESET;
    end else if (cfg_we_i) begin
      case (sne_pkg::cfg_index_e'(cfg_index_i))
        sne_pkg::CFG_IMAGE_WIDTH: width_q   <= cfg_data_i[sne_pkg::WIDTH_W-1:0];
        sne_pkg::CFG_SHIFT_X:     shift_x_q <= cfg_data_i[sne_pkg::SHIFT_W-1:0];
        sne_pkg::CFG_SHIFT_Y:     shift_y_q <= cfg_data_i[sne_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero width acts as one, oversize acts as the largest row
  always_comb begin
    width_eff = width_q;
    if (width_q == '0) begin
      width_eff = sne_pkg::WIDTH_W'(1);
    end else if (32'(width_q) > sne_pkg::MAX_WIDTH) begin
      width_eff = sne_pkg::WIDTH_W'(sne_pkg::MAX_WIDTH);
    end
  end

  // distance back to the shifted pixel, modulo the store depth
  assign prod       = sne_pkg::PROD_W'(shift_y_q) * sne_pkg::PROD_W'(width_eff);
  assign offset_sum = (sne_pkg::PROD_W + 1)'(prod) + (sne_pkg::PROD_W + 1)'(shift_x_q);
  assign offset     = sne_pkg::ADDR_W'(offset_sum);

  assign col_cur  = start_of_frame_i ? '0 : col_q;
  assign row_cur  = start_of_frame_i ? '0 : row_q;
  assign col_next = sne_pkg::CMP_W'(col_cur) + sne_pkg::CMP_W'(1);

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    item_o.pixel   = pixel_in_i;
    item_o.hit     = (row_cur >= shift_y_q) && (col_cur >= sne_pkg::COL_W'(shift_x_q));
    item_o.same    = (offset == '0);
    item_o.wr_addr = ptr_q;
    item_o.rd_addr = ptr_q - offset;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    ptr_d = ptr_q;
    if (push_o) begin
      ptr_d = ptr_q + sne_pkg::ADDR_W'(1);
      if (col_next >= sne_pkg::CMP_W'(width_eff)) begin
        col_d = '0;
        row_d = (row_cur < sne_pkg::ROW_LIMIT) ? row_cur + sne_pkg::ROW_W'(1) : row_cur;
      end else begin
        col_d = sne_pkg::COL_W'(col_next);
        row_d = row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      ptr_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      ptr_q <= ptr_d;
    end
  end

endmodule

// ----- design/sne_fifo.sv -----
// short queue of classified pixels between front and back
module sne_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sne_pkg::sne_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output sne_pkg::sne_item_t item_o
);

  sne_pkg::sne_item_t               slot_q [sne_pkg::QUEUE_DEPTH];
  logic [sne_pkg::QPTR_W-1:0]       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [sne_pkg::QCNT_W-1:0]       count_q, count_d;

  assign full_o  = (count_q == sne_pkg::QCNT_W'(sne_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = slot_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == sne_pkg::QPTR_W'(sne_pkg::QUEUE_DEPTH - 1)) ? '0
             : wptr_q + sne_pkg::QPTR_W'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == sne_pkg::QPTR_W'(sne_pkg::QUEUE_DEPTH - 1)) ? '0
             : rptr_q + sne_pkg::QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + sne_pkg::QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - sne_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= item_i;
    end
  end

endmodule

// ----- design/sne_back.sv -----
// back end: delay store, emboss arithmetic and output register
module sne_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      item_valid_i,
  input  sne_pkg::sne_item_t        item_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [sne_pkg::PIX_W-1:0] pixel_out_o
);

  logic [sne_pkg::PIX_W-1:0] store_q [sne_pkg::DELAY_DEPTH];
  logic [sne_pkg::PIX_W-1:0] rdata_q;
  logic                      s1_valid_q, s1_valid_d;
  logic [sne_pkg::PIX_W-1:0] s1_pix_q;
  logic                      s1_hit_q, s1_same_q;
  logic                      out_valid_q, out_valid_d;
  logic [sne_pkg::PIX_W-1:0] out_pix_q;
  logic                      out_en, s1_adv;
  logic [sne_pkg::PIX_W-1:0] old_pix, neg_pix, result;
  logic [sne_pkg::PIX_W:0]   sum;

  assign out_en = !out_valid_q || !out_stall_i;
  assign s1_adv = !s1_valid_q || out_en;
  assign pop_o  = s1_adv && item_valid_i;

  // write and read in the same beat; a zero offset reads the pixel itself
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      store_q[item_i.wr_addr] <= item_i.pixel;
      rdata_q                 <= store_q[item_i.rd_addr];
      s1_pix_q                <= item_i.pixel;
      s1_hit_q                <= item_i.hit;
      s1_same_q               <= item_i.same;
    end
  end

  always_comb begin
    old_pix = s1_same_q ? s1_pix_q : rdata_q;
    neg_pix = s1_hit_q ? sne_pkg::PIX_MAX - old_pix : sne_pkg::NEUTRAL;
    sum     = {1'b0, s1_pix_q} + {1'b0, neg_pix};
    if (sum < (sne_pkg::PIX_W + 1)'(sne_pkg::NEUTRAL)) begin
      result = '0;
    end else if (sum > (sne_pkg::PIX_W + 1)'(sne_pkg::NEUTRAL)
                     + (sne_pkg::PIX_W + 1)'(sne_pkg::PIX_MAX)) begin
      result = sne_pkg::PIX_MAX;
    end else begin
      result = sne_pkg::PIX_W'(sum - (sne_pkg::PIX_W + 1)'(sne_pkg::NEUTRAL));
    end
  end

  assign s1_valid_d  = s1_adv ? item_valid_i : s1_valid_q;
  assign out_valid_d = out_en ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s1_valid_q) begin
      out_pix_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = out_pix_q;

endmodule

// ----- design/sne_checker.sv -----
// port-level checker of the emboss core and its bind
`include "shifted_negative_emboss_core_assert.svh"

module sne_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [sne_pkg::PIX_W-1:0] pixel_out_o
);

  // nothing pending and nothing blocked while in reset
  `SNE_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> (!out_valid_o && !in_stall_o),
                     "busy in reset")

  // the queue only fills behind a held result
  `SNE_ASSERT(a_stall_needs_result, !out_valid_o |-> !in_stall_o,
              "input stalled with output empty")

  // a drained result frees a queue slot for the next beat
  `SNE_ASSERT(a_drain_frees, (out_valid_o && !out_stall_i) |=> !in_stall_o,
              "no slot after drain")

  `SNE_ASSERT(a_out_hold,
              (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(pixel_out_o)),
              "stalled result changed")

endmodule

bind shifted_negative_emboss_core sne_checker u_sne_checker (.*);
